// ----- rtl/key_action_map_table_defines.svh -----
// Assertion macros used by the key action map table top level.
`ifndef KEY_ACTION_MAP_TABLE_DEFINES_SVH
`define KEY_ACTION_MAP_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define KAMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KAMT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KAMT_ASSERT(lbl, prop, msg)
`define KAMT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/kamt_pkg.sv -----
`timescale 1ns / 1ps
// Types and codes shared by the key action map table modules.
package kamt_pkg;

  localparam int KEY_W  = 16;
  localparam int ACT_W  = 7;
  localparam int USED_W = 8;

  typedef logic [USED_W-1:0] used_t;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ACT_W-1:0] act;
  } entry_t;

endpackage

// ----- rtl/kamt_ram.sv -----
`timescale 1ns / 1ps
// Entry memory with one write port and one registered read port.
module kamt_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  kamt_pkg::entry_t  wdata,
  input  logic [AW-1:0]     raddr,
  output kamt_pkg::entry_t  rdata
);

  kamt_pkg::entry_t mem [DEPTH];
  kamt_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/key_action_map_table.sv -----
`timescale 1ns / 1ps
// Top level of the key action map table: sequencer, entry memory and result register.
// The table is a packed list of key and action entries in one memory with a registered read
// port, and every lookup, add or remove walks it through that single port, one entry per
// cycle, from index 0 until the key matches or the valid entries run out. A hit on add
// rewrites the action in place; a miss on add appends the entry or reports full. A remove
// that hits then moves each later entry down one place. A clear resets the entry count
// without walking the table. A new beat is accepted only while the sequencer is idle, but a
// finished result may still wait in the output register. No clearing pass runs after reset.
`include "key_action_map_table_defines.svh"
module key_action_map_table #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [15:0] in_key_code,
  input  logic [6:0] in_action_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_hit,
  output logic [6:0] out_bound_action,
  output logic [1:0] out_status,
  output logic [7:0] out_entries_used
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef logic [CW-1:0] cnt_t;
  typedef logic [AW-1:0] addr_t;

  kamt_pkg::state_t  state_r, state_nxt;
  kamt_pkg::op_t     op_r, op_nxt;
  logic [kamt_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [kamt_pkg::ACT_W-1:0] act_r, act_nxt;
  cnt_t              count_r, count_nxt;
  cnt_t              idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  addr_t             pend_idx_r, pend_idx_nxt;

  logic              res_hit_r, res_hit_nxt;
  logic [kamt_pkg::ACT_W-1:0] res_act_r, res_act_nxt;
  kamt_pkg::status_t res_status_r, res_status_nxt;
  kamt_pkg::used_t   res_used_r, res_used_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic [kamt_pkg::ACT_W-1:0] out_act_r, out_act_nxt;
  kamt_pkg::status_t out_status_r, out_status_nxt;
  kamt_pkg::used_t   out_used_r, out_used_nxt;

  logic              ram_we;
  addr_t             ram_waddr;
  kamt_pkg::entry_t  ram_wdata;
  addr_t             ram_raddr;
  kamt_pkg::entry_t  ram_rdata;
  logic              match;

  kamt_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall         = (state_r != kamt_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_bound_action = out_act_r;
  assign out_status       = out_status_r;
  assign out_entries_used = out_used_r;

  assign match = pend_r && (ram_rdata.key == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kamt_pkg::S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    act_r        <= act_nxt;
    idx_r        <= idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    res_hit_r    <= res_hit_nxt;
    res_act_r    <= res_act_nxt;
    res_status_r <= res_status_nxt;
    res_used_r   <= res_used_nxt;
    out_hit_r    <= out_hit_nxt;
    out_act_r    <= out_act_nxt;
    out_status_r <= out_status_nxt;
    out_used_r   <= out_used_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    act_nxt        = act_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    res_hit_nxt    = res_hit_r;
    res_act_nxt    = res_act_r;
    res_status_nxt = res_status_r;
    res_used_nxt   = res_used_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_hit_nxt    = out_hit_r;
    out_act_nxt    = out_act_r;
    out_status_nxt = out_status_r;
    out_used_nxt   = out_used_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = idx_r[AW-1:0];

    unique case (state_r)
      kamt_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt         = kamt_pkg::op_t'(in_operation);
          key_nxt        = in_key_code;
          act_nxt        = in_action_code;
          idx_nxt        = '0;
          pend_nxt       = 1'b0;
          res_hit_nxt    = 1'b0;
          res_act_nxt    = '0;
          res_status_nxt = kamt_pkg::ST_OK;
          res_used_nxt   = kamt_pkg::used_t'(count_r);
          if (kamt_pkg::op_t'(in_operation) == kamt_pkg::OP_CLEAR) begin
            count_nxt    = '0;
            res_used_nxt = '0;
            state_nxt    = kamt_pkg::S_RESULT;
          end else begin
            state_nxt    = kamt_pkg::S_SCAN;
          end
        end
      end

      kamt_pkg::S_SCAN: begin
        priority if (match) begin
          pend_nxt    = 1'b0;
          res_hit_nxt = 1'b1;
          unique case (op_r)
            kamt_pkg::OP_LOOKUP: begin
              res_act_nxt = ram_rdata.act;
              state_nxt   = kamt_pkg::S_RESULT;
            end
            kamt_pkg::OP_ADD: begin
              ram_we    = 1'b1;
              ram_waddr = pend_idx_r;
              ram_wdata = '{key: key_r, act: act_r};
              state_nxt = kamt_pkg::S_RESULT;
            end
            kamt_pkg::OP_REMOVE: begin
              idx_nxt   = cnt_t'(pend_idx_r) + cnt_t'(1);
              state_nxt = kamt_pkg::S_SHIFT;
            end
            default: begin
              state_nxt = kamt_pkg::S_RESULT;
            end
          endcase
        end else if (idx_r < count_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[AW-1:0];
          idx_nxt      = idx_r + cnt_t'(1);
        end else if (!pend_r) begin
          state_nxt = kamt_pkg::S_RESULT;
          unique case (op_r)
            kamt_pkg::OP_ADD: begin
              if (count_r == cnt_t'(TABLE_DEPTH)) begin
                res_status_nxt = kamt_pkg::ST_FULL;
              end else begin
                ram_we       = 1'b1;
                ram_waddr    = count_r[AW-1:0];
                ram_wdata    = '{key: key_r, act: act_r};
                count_nxt    = count_r + cnt_t'(1);
                res_used_nxt = kamt_pkg::used_t'(count_r + cnt_t'(1));
              end
            end
            kamt_pkg::OP_REMOVE: begin
              res_status_nxt = kamt_pkg::ST_MISSING;
            end
            default: begin
              res_status_nxt = kamt_pkg::ST_OK;
            end
          endcase
        end else begin
          pend_nxt = 1'b0;
        end
      end

      kamt_pkg::S_SHIFT: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_r - addr_t'(1);
          ram_wdata = ram_rdata;
        end
        if (idx_r < count_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[AW-1:0];
          idx_nxt      = idx_r + cnt_t'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt    = count_r - cnt_t'(1);
            res_used_nxt = kamt_pkg::used_t'(count_r - cnt_t'(1));
            state_nxt    = kamt_pkg::S_RESULT;
          end
        end
      end

      kamt_pkg::S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = res_hit_r;
          out_act_nxt    = res_act_r;
          out_status_nxt = res_status_r;
          out_used_nxt   = res_used_r;
          state_nxt      = kamt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = kamt_pkg::S_IDLE;
      end
    endcase
  end

  `KAMT_ASSERT(a_count_bound, count_r <= cnt_t'(TABLE_DEPTH), "entry count above table depth")
  `KAMT_ASSERT(a_clear_empties,
    (in_valid && !in_stall && in_operation == kamt_pkg::OP_CLEAR) |=> (count_r == '0),
    "clear did not empty the table")
  `KAMT_ASSERT(a_count_step,
    1'b1 |=> (count_r == $past(count_r) || count_r == $past(count_r) + cnt_t'(1) ||
              count_r + cnt_t'(1) == $past(count_r) || count_r == '0),
    "entry count jumped")
  `KAMT_ASSERT(a_idle_no_write, (state_r == kamt_pkg::S_IDLE) |-> !ram_we, "memory written while idle")
  `KAMT_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_valid_r, "result valid right after reset")

endmodule
